@@ sv/vlcd_pkg.sv @@
// Package for the variable length code decoder.
// Holds the request kind and result status codes, the controller state type
// and the token that ripples along the codebook cell chain. No dependencies.
`default_nettype none

package vlcd_pkg;

    // Default sizing of the codebook
    localparam int ENTRIES_DEF       = 32;
    localparam int MAX_CODE_BITS_DEF = 16;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 5;
    localparam int INCODE_W = 16;
    localparam int INLEN_W  = 5;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 32;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BIT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_SYMBOL   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_END_OK   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_END_FAIL = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_RESOLVE
    } ctrl_state_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             found;
        logic             ext;
        logic [SYM_W-1:0] symbol;
    } vlcd_token_t;

endpackage

`default_nettype wire

@@ sv/vlcd_in_if.sv @@
// Input channel of the variable length code decoder: valid/ready plus the
// request payload (load, bit or end). Depends on vlcd_pkg for field widths.
`default_nettype none

interface vlcd_in_if;
    logic                            valid;
    logic                            ready;
    logic [vlcd_pkg::KIND_W-1:0]     kind;
    logic [vlcd_pkg::INDEX_W-1:0]    entry_index;
    logic [vlcd_pkg::INCODE_W-1:0]   entry_code;
    logic [vlcd_pkg::INLEN_W-1:0]    entry_length;
    logic [vlcd_pkg::SYM_W-1:0]      entry_symbol;
    logic                            bit_value;

    modport source (
        output valid, kind, entry_index, entry_code, entry_length, entry_symbol,
               bit_value,
        input  ready
    );

    modport sink (
        input  valid, kind, entry_index, entry_code, entry_length, entry_symbol,
               bit_value,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/vlcd_out_if.sv @@
// Result channel of the variable length code decoder: valid/ready plus
// status, symbol and error position. Depends on vlcd_pkg for field widths.
`default_nettype none

interface vlcd_out_if;
    logic                            valid;
    logic                            ready;
    logic [vlcd_pkg::STATUS_W-1:0]   status;
    logic [vlcd_pkg::SYM_W-1:0]      symbol;
    logic [vlcd_pkg::POS_W-1:0]      error_position;

    modport source (
        output valid, status, symbol, error_position,
        input  ready
    );

    modport sink (
        input  valid, status, symbol, error_position,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/vlcd_cell.sv @@
// One codebook slot of the decoder chain: stores code, length and symbol,
// compares them with the broadcast pending bits and folds the result into
// the token passed to the next cell. Depends on vlcd_pkg.
`default_nettype none

module vlcd_cell #(
    parameter int MAX_CODE_BITS = vlcd_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [MAX_CODE_BITS-1:0]              wr_code,
    input  wire logic [$clog2(MAX_CODE_BITS+1)-1:0]    wr_len,
    input  wire logic [vlcd_pkg::SYM_W-1:0]            wr_sym,
    input  wire logic [MAX_CODE_BITS-1:0]              pend_bits,
    input  wire logic [$clog2(MAX_CODE_BITS+1)-1:0]    pend_count,
    input  wire vlcd_pkg::vlcd_token_t                 tok_in,
    output      vlcd_pkg::vlcd_token_t                 tok_out
);

    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

    logic [MAX_CODE_BITS-1:0]   code_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [vlcd_pkg::SYM_W-1:0] sym_reg;
    vlcd_pkg::vlcd_token_t      tok_reg;
    vlcd_pkg::vlcd_token_t      tok_next;

    logic             live;
    logic [LEN_W-1:0] shamt;
    logic             prefix;
    logic             exact;

    // Slot length: zero marks the slot empty after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else if (wr_en)
            len_reg <= wr_len;
    end

    // Slot code and symbol, only read once the length is nonzero
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_reg <= wr_code;
            sym_reg  <= wr_sym;
        end
    end

    // Prefix compare against the pending bits
    always_comb
    begin
        live   = (len_reg != '0) && (len_reg >= pend_count);
        shamt  = len_reg - pend_count;
        prefix = live && ((code_reg >> shamt) == pend_bits);
        exact  = prefix && (len_reg == pend_count);
    end

    // Fold into the token; an earlier slot's match keeps priority
    always_comb
    begin
        tok_next.valid  = tok_in.valid;
        tok_next.found  = tok_in.found || exact;
        tok_next.ext    = tok_in.ext || (prefix && !exact);
        tok_next.symbol = (!tok_in.found && exact) ? sym_reg : tok_in.symbol;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

@@ sv/vlcd_ctrl.sv @@
// Stream controller of the decoder: pending bits, stream position, failure
// flag, launch and resolution of the chain search, and the result register.
// Depends on vlcd_pkg, vlcd_in_if and vlcd_out_if.
`default_nettype none

module vlcd_ctrl #(
    parameter int MAX_CODE_BITS = vlcd_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    vlcd_in_if.sink                                    stream,
    vlcd_out_if.source                                 result,
    output      logic [MAX_CODE_BITS-1:0]              pend_bits,
    output      logic [$clog2(MAX_CODE_BITS+1)-1:0]    pend_count,
    output      vlcd_pkg::vlcd_token_t                 chain_in,
    input  wire vlcd_pkg::vlcd_token_t                 chain_out
);

    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
    localparam int POS_W = vlcd_pkg::POS_W;

    vlcd_pkg::ctrl_state_t state_reg, state_next;

    logic [MAX_CODE_BITS-1:0]      pend_bits_reg, pend_bits_next;
    logic [LEN_W-1:0]              pend_count_reg, pend_count_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [POS_W-1:0]              start_reg, start_next;
    logic                          failed_reg, failed_next;
    logic                          launch_reg, launch_next;
    vlcd_pkg::vlcd_token_t         res_reg, res_next;
    logic                          out_valid_reg, out_valid_next;
    logic [vlcd_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [vlcd_pkg::SYM_W-1:0]    out_symbol_reg, out_symbol_next;
    logic [POS_W-1:0]              out_pos_reg, out_pos_next;

    logic acc;
    logic out_free;
    logic need_out;
    logic bit_go;

    assign out_free = !out_valid_reg || result.ready;
    assign need_out = res_reg.found || !res_reg.ext;
    assign stream.ready = (state_reg == vlcd_pkg::S_IDLE)
                          && (out_free || (stream.kind != vlcd_pkg::KIND_END));
    assign acc    = stream.valid && stream.ready;
    assign bit_go = acc && (stream.kind == vlcd_pkg::KIND_BIT) && !failed_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vlcd_pkg::S_IDLE:
            begin
                if (bit_go)
                    state_next = vlcd_pkg::S_SWEEP;
            end
            vlcd_pkg::S_SWEEP:
            begin
                if (chain_out.valid)
                    state_next = vlcd_pkg::S_RESOLVE;
            end
            vlcd_pkg::S_RESOLVE:
            begin
                if (!need_out || out_free)
                    state_next = vlcd_pkg::S_IDLE;
            end
            default:
                state_next = vlcd_pkg::S_IDLE;
        endcase
    end

    // Datapath and result register
    always_comb
    begin
        pend_bits_next  = pend_bits_reg;
        pend_count_next = pend_count_reg;
        pos_next        = pos_reg;
        start_next      = start_reg;
        failed_next     = failed_reg;
        launch_next     = bit_go;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_symbol_next = out_symbol_reg;
        out_pos_next    = out_pos_reg;

        case (state_reg)
            vlcd_pkg::S_IDLE:
            begin
                if (acc && (stream.kind == vlcd_pkg::KIND_BIT))
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (!failed_reg)
                    begin
                        if (pend_count_reg == '0)
                            start_next = pos_reg;
                        pend_bits_next  = {pend_bits_reg[MAX_CODE_BITS-2:0], stream.bit_value};
                        pend_count_next = pend_count_reg + LEN_W'(1);
                    end
                end
                else if (acc && (stream.kind == vlcd_pkg::KIND_END))
                begin
                    out_valid_next  = 1'b1;
                    out_symbol_next = '0;
                    if (failed_reg || (pend_count_reg != '0))
                    begin
                        out_status_next = vlcd_pkg::STATUS_END_FAIL;
                        out_pos_next    = start_reg;
                    end
                    else
                    begin
                        out_status_next = vlcd_pkg::STATUS_END_OK;
                        out_pos_next    = '0;
                    end
                    pend_bits_next  = '0;
                    pend_count_next = '0;
                    pos_next        = '0;
                    start_next      = '0;
                    failed_next     = 1'b0;
                end
            end
            vlcd_pkg::S_SWEEP:
            begin
                if (chain_out.valid)
                    res_next = chain_out;
            end
            vlcd_pkg::S_RESOLVE:
            begin
                if (need_out && out_free)
                begin
                    out_valid_next  = 1'b1;
                    pend_bits_next  = '0;
                    pend_count_next = '0;
                    if (res_reg.found)
                    begin
                        out_status_next = vlcd_pkg::STATUS_SYMBOL;
                        out_symbol_next = res_reg.symbol;
                        out_pos_next    = '0;
                    end
                    else
                    begin
                        out_status_next = vlcd_pkg::STATUS_INVALID;
                        out_symbol_next = '0;
                        out_pos_next    = start_reg;
                        failed_next     = 1'b1;
                    end
                end
            end
            default:
            begin
                launch_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vlcd_pkg::S_IDLE;
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
            pos_reg        <= '0;
            start_reg      <= '0;
            failed_reg     <= 1'b0;
            launch_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
            pos_reg        <= pos_next;
            start_reg      <= start_next;
            failed_reg     <= failed_next;
            launch_reg     <= launch_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_symbol_reg <= out_symbol_next;
        out_pos_reg    <= out_pos_next;
    end

    assign pend_bits  = pend_bits_reg;
    assign pend_count = pend_count_reg;

    // Fresh token into the first cell, in the cycle after the bit is taken
    always_comb
    begin
        chain_in        = '0;
        chain_in.valid  = launch_reg;
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_status_reg;
    assign result.symbol         = out_symbol_reg;
    assign result.error_position = out_pos_reg;

    // Checks
    a_token_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> (state_reg == vlcd_pkg::S_SWEEP))
        else $error("search token left the chain outside a sweep");

    a_launch_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> (state_reg == vlcd_pkg::S_SWEEP))
        else $error("token launched while not sweeping");

    a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != vlcd_pkg::S_IDLE) |-> (pend_count_reg != '0))
        else $error("search running with no pending bits");

    a_no_search_failed: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> !failed_reg)
        else $error("search launched after a failure");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pend_count_reg) <= 32'(MAX_CODE_BITS))
        else $error("pending count beyond longest code");

endmodule

`default_nettype wire

@@ sv/variable_length_code_decoder_top.sv @@
// Top level of the variable length code decoder.
// Depends on vlcd_pkg, vlcd_in_if, vlcd_out_if, vlcd_cell and vlcd_ctrl.
//
// Usage:
//   stream (sink) takes requests: kind LOAD writes one codebook slot, kind
//   BIT delivers one encoded bit, kind END closes the stream. result (source)
//   returns status, symbol and error_position. Both channels move a request
//   at a clock edge where valid and ready are high.
//   Load requests and bits after an invalid code take 1 cycle. A live bit
//   sends a search token down a chain of ENTRIES slot cells, one cell per
//   cycle. The token from the last cell is held in the result register, and
//   the resolve step writes a code or an invalid code to the output; the next
//   request is taken only after that step. An end request is answered in the
//   cycle after it is taken. The chain length sets the bit rate.
//   Reset (rst_n low, asynchronous) empties every slot and starts a new
//   stream; no clearing pass is needed. When the receiver stalls, the result
//   holds in its output register; loads and bits are still taken, an end
//   request waits for the register to drain, and a finished search waits in
//   the resolve step. The codebook survives an end request.
`default_nettype none

module variable_length_code_decoder_top #(
    parameter int ENTRIES       = vlcd_pkg::ENTRIES_DEF,
    parameter int MAX_CODE_BITS = vlcd_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vlcd_in_if.sink    stream,
    vlcd_out_if.source result
);

    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

    logic [MAX_CODE_BITS-1:0]          pend_bits;
    logic [LEN_W-1:0]                  pend_count;
    vlcd_pkg::vlcd_token_t             tok [ENTRIES+1];
    logic [ENTRIES-1:0]                wr_en;
    logic                              load_acc;
    logic [vlcd_pkg::INLEN_W-1:0]      len_eff;
    logic [vlcd_pkg::INCODE_W-1:0]     code_mask;
    logic [31:0]                       code_wide;
    logic [MAX_CODE_BITS-1:0]          wr_code;
    logic [LEN_W-1:0]                  wr_len;

    assign load_acc = stream.valid && stream.ready && (stream.kind == vlcd_pkg::KIND_LOAD);

    // Slot write data: overlong codes store an empty slot, unused bits cleared
    always_comb
    begin
        if (32'(stream.entry_length) > 32'(MAX_CODE_BITS))
            len_eff = '0;
        else
            len_eff = stream.entry_length;
        if (len_eff >= vlcd_pkg::INLEN_W'(vlcd_pkg::INCODE_W))
            code_mask = '1;
        else
            code_mask = vlcd_pkg::INCODE_W'((17'd1 << len_eff) - 17'd1);
        code_wide = 32'(stream.entry_code & code_mask);
        wr_code   = code_wide[MAX_CODE_BITS-1:0];
        wr_len    = LEN_W'(len_eff);
    end

    vlcd_ctrl #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .result     (result),
        .pend_bits  (pend_bits),
        .pend_count (pend_count),
        .chain_in   (tok[0]),
        .chain_out  (tok[ENTRIES])
    );

    // Slot cells; out-of-range indexes match no cell
    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        assign wr_en[k] = load_acc && (32'(stream.entry_index) == 32'(k));

        vlcd_cell #(
            .MAX_CODE_BITS (MAX_CODE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .wr_en      (wr_en[k]),
            .wr_code    (wr_code),
            .wr_len     (wr_len),
            .wr_sym     (stream.entry_symbol),
            .pend_bits  (pend_bits),
            .pend_count (pend_count),
            .tok_in     (tok[k]),
            .tok_out    (tok[k+1])
        );
    end

endmodule

`default_nettype wire

@@ tb/variable_length_code_decoder_top_test.sv @@
// Self-checking testbench for variable_length_code_decoder_top: a directed table, then
// random codebooks and bit streams, with every result compared against a local predictor.
// Depends on vlcd_pkg, vlcd_in_if, vlcd_out_if and the decoder RTL.
`default_nettype none

module variable_length_code_decoder_top_test;
    import vlcd_pkg::*;

    localparam int ENTRIES        = ENTRIES_DEF;
    localparam int CODE_BITS      = MAX_CODE_BITS_DEF;
    localparam int TARGET_ITEMS   = 700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 3 * (ENTRIES + 3);
    // Kind 3 is not decoded; the block must drop it
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [INDEX_W-1:0]  index;
        logic [INCODE_W-1:0] code;
        logic [INLEN_W-1:0]  length;
        logic [SYM_W-1:0]    sym;
        logic                bitv;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SYM_W-1:0]    symbol;
        logic [POS_W-1:0]    position;
    } decode_result_t;

    typedef struct packed {
        request_t       req;
        int             reps;
        logic           typed;
        logic           has;
        decode_result_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    vlcd_in_if  req_ch();
    vlcd_out_if res_ch();

    variable_length_code_decoder_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (req_ch),
        .result (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the codebook and stream state
    logic [CODE_BITS-1:0] book_code [ENTRIES];
    int                   book_len  [ENTRIES];
    logic [SYM_W-1:0]     book_sym  [ENTRIES];
    logic [CODE_BITS-1:0] pend_bits;
    int                   pend_cnt;
    logic [POS_W-1:0]     stream_pos;
    logic [POS_W-1:0]     code_start;
    logic                 failed;

    decode_result_t awaited_results[$];
    int             fail_count    = 0;
    int             sent_items    = 0;
    int             send_idle_pct = 12;
    int             recv_idle_pct = 52;

    // Stimulus generator's view of the codebook
    logic [ENTRIES-1:0]   slot_busy = '1;
    logic [CODE_BITS-1:0] live_code[$];
    int                   live_len[$];

    initial
    begin
        for (int s = 0; s < ENTRIES; s++)
        begin
            book_code[s] = '0;
            book_len[s]  = 0;
            book_sym[s]  = '0;
        end
        pend_bits  = '0;
        pend_cnt   = 0;
        stream_pos = '0;
        code_start = '0;
        failed     = 1'b0;
    end

    // Work out the result of one accepted request; returns 1 if it makes one
    function automatic logic predict_decode(input request_t r, output decode_result_t res);
        int   len;
        logic extendable;
        res        = '0;
        extendable = 1'b0;
        case (r.kind)
            KIND_LOAD:
            begin
                len = int'(r.length);
                if (len > CODE_BITS)
                    len = 0;
                book_len[r.index]  = len;
                book_code[r.index] = r.code & CODE_BITS'((32'd1 << len) - 32'd1);
                book_sym[r.index]  = r.sym;
                return 1'b0;
            end
            KIND_BIT:
            begin
                if (failed)
                begin
                    stream_pos++;
                    return 1'b0;
                end
                if (pend_cnt == 0)
                    code_start = stream_pos;
                stream_pos++;
                pend_bits = {pend_bits[CODE_BITS-2:0], r.bitv};
                pend_cnt++;
                for (int k = 0; k < ENTRIES; k++)
                begin
                    len = book_len[k];
                    if (len == 0 || len < pend_cnt)
                        continue;
                    // exact match: lowest slot wins
                    if (len == pend_cnt && book_code[k] == pend_bits)
                    begin
                        res.status = STATUS_SYMBOL;
                        res.symbol = book_sym[k];
                        pend_bits  = '0;
                        pend_cnt   = 0;
                        return 1'b1;
                    end
                    if ((book_code[k] >> (len - pend_cnt)) == pend_bits)
                        extendable = 1'b1;
                end
                if (!extendable)
                begin
                    failed       = 1'b1;
                    pend_bits    = '0;
                    pend_cnt     = 0;
                    res.status   = STATUS_INVALID;
                    res.position = code_start;
                    return 1'b1;
                end
                return 1'b0;
            end
            KIND_END:
            begin
                if (failed || pend_cnt != 0)
                begin
                    res.status   = STATUS_END_FAIL;
                    res.position = code_start;
                end
                else
                    res.status = STATUS_END_OK;
                pend_bits  = '0;
                pend_cnt   = 0;
                stream_pos = '0;
                code_start = '0;
                failed     = 1'b0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Present one request, wait for the handshake, then queue what it should produce
    task automatic send_req(input request_t r, input logic typed = 1'b0,
                            input logic typed_has = 1'b0,
                            input decode_result_t typed_want = '0);
        decode_result_t want;
        logic           has;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= r.kind;
        req_ch.entry_index  <= r.index;
        req_ch.entry_code   <= r.code;
        req_ch.entry_length <= r.length;
        req_ch.entry_symbol <= r.sym;
        req_ch.bit_value    <= r.bitv;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        has = predict_decode(r, want);
        if (typed)
        begin
            has  = typed_has;
            want = typed_want;
        end
        if (has)
            awaited_results.push_back(want);
        if (r.kind != KIND_NOP)
            sent_items++;
        // idling phases: slow receiver, then slow sender, then full rate
        if (sent_items < 250)
        begin
            send_idle_pct = 12;
            recv_idle_pct = 52;
        end
        else if (sent_items < 500)
        begin
            send_idle_pct = 52;
            recv_idle_pct = 12;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    function automatic request_t rand_req(input logic [KIND_W-1:0] kind);
        request_t r;
        r.kind   = kind;
        r.index  = INDEX_W'($urandom_range(31));
        r.code   = INCODE_W'($urandom_range(16'hFFFF));
        r.length = INLEN_W'($urandom_range(31));
        r.sym    = SYM_W'($urandom_range(255));
        r.bitv   = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic send_bit(input logic b);
        request_t r;
        r      = rand_req(KIND_BIT);
        r.bitv = b;
        send_req(r);
    endtask

    // Send a code first bit first
    task automatic send_code(input logic [CODE_BITS-1:0] code, input int len, input int upto);
        for (int b = len - 1; b >= len - upto; b--)
            send_bit(code[b]);
    endtask

    function automatic plan_row_t mk_row(input logic [KIND_W-1:0] kind, input int index,
                                         input int code, input int length, input int sym,
                                         input int bitv, input int reps, input logic typed,
                                         input logic has, input logic [STATUS_W-1:0] st,
                                         input int osym, input int pos);
        plan_row_t row;
        row.req           = rand_req(kind);
        if (kind == KIND_LOAD)
        begin
            row.req.index  = INDEX_W'(index);
            row.req.code   = INCODE_W'(code);
            row.req.length = INLEN_W'(length);
            row.req.sym    = SYM_W'(sym);
        end
        if (kind == KIND_BIT)
            row.req.bitv = 1'(bitv);
        row.reps          = reps;
        row.typed         = typed;
        row.has           = has;
        row.want.status   = st;
        row.want.symbol   = SYM_W'(osym);
        row.want.position = POS_W'(pos);
        return row;
    endfunction

    // Clear the old codebook, then load a random prefix code with some gaps and at times one duplicate
    task automatic build_codebook();
        logic [CODE_BITS-1:0] leaf_code [20];
        int                   leaf_len  [20];
        logic [ENTRIES-1:0]   taken;
        logic [31:0]          garbage;
        request_t             r;
        int                   n, target, maxd, i, slot, j;
        logic                 deep;
        for (int s = 0; s < ENTRIES; s++)
        begin
            if (slot_busy[s])
            begin
                r        = rand_req(KIND_LOAD);
                r.index  = INDEX_W'(s);
                // empty the slot by a zero or an overlong length
                r.length = $urandom_range(1) ? '0 : INLEN_W'($urandom_range(31, CODE_BITS + 1));
                send_req(r);
            end
        end
        slot_busy = '0;
        taken     = '0;
        live_code.delete();
        live_len.delete();
        deep   = ($urandom_range(9) == 0);
        target = deep ? $urandom_range(17, 12) : $urandom_range(12, 2);
        maxd   = deep ? CODE_BITS : 6;
        leaf_code[0] = '0;
        leaf_len[0]  = 0;
        n = 1;
        while (n < target)
        begin
            i = deep ? n - 1 : $urandom_range(n - 1);
            if (leaf_len[i] < maxd)
            begin
                leaf_code[n] = {leaf_code[i][CODE_BITS-2:0], 1'b1};
                leaf_len[n]  = leaf_len[i] + 1;
                leaf_code[i] = {leaf_code[i][CODE_BITS-2:0], 1'b0};
                leaf_len[i]  = leaf_len[i] + 1;
                n++;
            end
        end
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(9) != 0 || (i == n - 1 && live_code.size() == 0))
            begin
                do
                    slot = $urandom_range(ENTRIES - 1);
                while (taken[slot]);
                taken[slot]     = 1'b1;
                slot_busy[slot] = 1'b1;
                // junk above the code length must be ignored
                garbage  = $urandom_range(16'hFFFF) << leaf_len[i];
                r        = rand_req(KIND_LOAD);
                r.index  = INDEX_W'(slot);
                r.code   = leaf_code[i] | garbage[CODE_BITS-1:0];
                r.length = INLEN_W'(leaf_len[i]);
                send_req(r);
                live_code.push_back(leaf_code[i]);
                live_len.push_back(leaf_len[i]);
            end
        end
        // duplicate code in another slot
        if ($urandom_range(99) < 15)
        begin
            j = $urandom_range(live_code.size() - 1);
            do
                slot = $urandom_range(ENTRIES - 1);
            while (taken[slot]);
            slot_busy[slot] = 1'b1;
            r        = rand_req(KIND_LOAD);
            r.index  = INDEX_W'(slot);
            r.code   = live_code[j];
            r.length = INLEN_W'(live_len[j]);
            send_req(r);
        end
    endtask

    // One stream: mostly valid symbol sequences, some truncated, some noise
    task automatic play_stream();
        request_t r;
        int       mode, nsym, j, cnt, p;
        mode = $urandom_range(99);
        if (mode < 85)
        begin
            nsym = (mode < 70) ? $urandom_range(10, 1) : $urandom_range(4);
            repeat (nsym)
            begin
                j = $urandom_range(live_code.size() - 1);
                send_code(live_code[j], live_len[j], live_len[j]);
            end
            if (mode >= 70)
            begin
                // partial code, possibly followed by stray bits
                j = $urandom_range(live_code.size() - 1);
                send_code(live_code[j], live_len[j], $urandom_range(live_len[j] - 1));
                repeat ($urandom_range(4))
                    send_bit(1'($urandom_range(1)));
            end
            else if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(3, 1))
                    send_bit(1'($urandom_range(1)));
            end
        end
        else
        begin
            cnt = $urandom_range(24, 1);
            repeat (cnt)
            begin
                p = $urandom_range(19);
                if (p == 0)
                    send_req(rand_req(KIND_NOP));
                else if (p == 1)
                begin
                    r = rand_req(KIND_LOAD);
                    if (r.length != 0 && r.length <= CODE_BITS)
                        slot_busy[r.index] = 1'b1;
                    send_req(r);
                end
                else
                    send_bit(1'($urandom_range(1)));
            end
        end
        send_req(rand_req(KIND_END));
    endtask

    // Receiver: random back-pressure, result check and watchdog
    initial
    begin
        int             stall_cycles;
        decode_result_t want;
        stall_cycles = 0;
        res_ch.ready <= 1'b0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n === 1'b1)
            begin
                if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                begin
                    if (awaited_results.size() == 0)
                    begin
                        $display("%0t: unexpected result: expected none, %s %0d %s %02h %s %0d",
                                 $time, "got status", res_ch.status, "symbol",
                                 res_ch.symbol, "position", res_ch.error_position);
                        fail_count++;
                    end
                    else
                    begin
                        want = awaited_results.pop_front();
                        if (res_ch.status !== want.status || res_ch.symbol !== want.symbol ||
                            res_ch.error_position !== want.position)
                        begin
                            $display("%0t: expected status %0d symbol %02h position %0d,",
                                     $time, want.status, want.symbol, want.position);
                            $display("%0t:      got status %0d symbol %02h position %0d",
                                     $time, res_ch.status, res_ch.symbol,
                                     res_ch.error_position);
                            fail_count++;
                        end
                    end
                end
                if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                    (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                    stall_cycles = 0;
                else
                    stall_cycles++;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        $display("variable_length_code_decoder_top: mismatch");
        $finish;
    end

    // Sender: reset, directed table, then random codebooks and streams
    initial
    begin
        plan_row_t plan[$];
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= KIND_LOAD;
        req_ch.entry_index  <= '0;
        req_ch.entry_code   <= '0;
        req_ch.entry_length <= '0;
        req_ch.entry_symbol <= '0;
        req_ch.bit_value    <= 1'b0;
        rst_n               <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty codebook: clean end, invalid first bit, bits ignored after failure
        plan.push_back(mk_row(KIND_END, 0, 0, 0, 0, 0, 1, 1'b1, 1'b1, STATUS_END_OK, 0, 0));
        plan.push_back(mk_row(KIND_BIT, 0, 0, 0, 0, 0, 1, 1'b1, 1'b1, STATUS_INVALID, 0, 0));
        plan.push_back(mk_row(KIND_BIT, 0, 0, 0, 0, 1, 1, 1'b1, 1'b0, STATUS_SYMBOL, 0, 0));
        plan.push_back(mk_row(KIND_END, 0, 0, 0, 0, 0, 1, 1'b1, 1'b1, STATUS_END_FAIL, 0, 0));
        // "1" in slot 0 with junk high bits, sixteen zeros in the top slot,
        // an overlong load and a duplicate of "1" in a higher slot
        plan.push_back(mk_row(KIND_LOAD, 0, 16'hFFFF, 1, 8'hFF, 0, 1, 1'b1, 1'b0, STATUS_SYMBOL, 0, 0));
        plan.push_back(mk_row(KIND_LOAD, 31, 16'h0000, 16, 8'h00, 0, 1, 1'b1, 1'b0, STATUS_SYMBOL, 0, 0));
        plan.push_back(mk_row(KIND_LOAD, 5, 16'hFFFF, 31, 8'hAA, 0, 1, 1'b1, 1'b0, STATUS_SYMBOL, 0, 0));
        plan.push_back(mk_row(KIND_LOAD, 7, 16'h0001, 1, 8'h11, 0, 1, 1'b1, 1'b0, STATUS_SYMBOL, 0, 0));
        plan.push_back(mk_row(KIND_NOP, 0, 0, 0, 0, 0, 1, 1'b1, 1'b0, STATUS_SYMBOL, 0, 0));
        plan.push_back(mk_row(KIND_BIT, 0, 0, 0, 0, 1, 1, 1'b1, 1'b1, STATUS_SYMBOL, 8'hFF, 0));
        plan.push_back(mk_row(KIND_BIT, 0, 0, 0, 0, 0, 15, 1'b0, 1'b0, STATUS_SYMBOL, 0, 0));
        plan.push_back(mk_row(KIND_BIT, 0, 0, 0, 0, 0, 1, 1'b1, 1'b1, STATUS_SYMBOL, 8'h00, 0));
        // end with one bit pending, started at bit 17
        plan.push_back(mk_row(KIND_BIT, 0, 0, 0, 0, 0, 1, 1'b0, 1'b0, STATUS_SYMBOL, 0, 0));
        plan.push_back(mk_row(KIND_END, 0, 0, 0, 0, 0, 1, 1'b1, 1'b1, STATUS_END_FAIL, 0, 17));

        foreach (plan[p])
        begin
            repeat (plan[p].reps)
                send_req(plan[p].req, plan[p].typed, plan[p].has, plan[p].want);
        end

        while (sent_items < TARGET_ITEMS)
        begin
            if (live_code.size() == 0 || $urandom_range(4) == 0)
                build_codebook();
            play_stream();
        end
        req_ch.valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("variable_length_code_decoder_top: match");
        else
            $display("variable_length_code_decoder_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
sv/vlcd_pkg.sv
sv/vlcd_in_if.sv
sv/vlcd_out_if.sv
sv/vlcd_cell.sv
sv/vlcd_ctrl.sv
sv/variable_length_code_decoder_top.sv
tb/variable_length_code_decoder_top_test.sv
